// ----- rtl/mrfr_pkg.sv -----
// ----------------------------------------------------------------------------
// mrfr_pkg: shared definitions for the frame receiver
// Buffer sizing, request and result codes, register indexes, result type and
// the Modbus CRC-16 byte update.
// ----------------------------------------------------------------------------
package mrfr_pkg;

    // frame buffer and length limits
    localparam int BUF_BYTES       = 256;
    localparam int MIN_FRAME_BYTES = 4;
    localparam int CHECK_MIN_BYTES = 4;
    localparam int ADDR_W          = $clog2(BUF_BYTES);
    localparam int CNT_W           = $clog2(BUF_BYTES + 1);

    // output queue sizing
    localparam int OQ_DEPTH = 3;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    // request codes
    localparam logic [1:0] REQ_BYTE = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    // result kinds
    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_READ    = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_SLAVE_ADDR = 2'd0;
    localparam logic [1:0] CFG_T15_TICKS  = 2'd1;
    localparam logic [1:0] CFG_T35_TICKS  = 2'd2;

    // register reset values
    localparam logic [7:0]  SLAVE_ADDR_RST = 8'd1;
    localparam logic [15:0] T15_TICKS_RST  = 16'd16;
    localparam logic [15:0] T35_TICKS_RST  = 16'd36;

    localparam logic [7:0]  BCAST_ADDR = 8'd0;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    typedef struct packed {
        logic       kind;
        logic       good;
        logic [8:0] length;
        logic [7:0] data;
    } mrfr_result_t;

    // reflected crc-16, one byte, eight shift steps
    function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                 input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- rtl/modbus_rtu_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// modbus_rtu_frame_receiver: Modbus RTU frame delimiting and checking
// a result passes through the result register, then the output queue,
//   before it is offered on out_valid
// throughput: one request per cycle; in_stall rises only when the result
//   register and the three-entry output queue together hold three results
// reset: asynchronous, active low; timers disarmed, byte count 0, crc 0xFFFF,
//   registers to address 1 and 16/36 ticks; the frame buffer is not cleared
// ----------------------------------------------------------------------------
module modbus_rtu_frame_receiver
    import mrfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [7:0]  rx_byte,
    input  logic [7:0]  read_index,

    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic        frame_good,
    output logic [8:0]  frame_length,
    output logic [7:0]  read_data,

    // register write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic                in_accept;
    logic                res_valid;
    mrfr_result_t        res;
    mrfr_result_t        out_data;
    logic [OQ_CNT_W-1:0] oq_count;
    logic [OQ_CNT_W:0]   occupancy;

    // registers are always writable; the user must make writes only while idle, the block does not enforce it
    assign cfg_ready = 1'b1;

    // results in flight: queue entries plus the one in the result register.
    // stall comes only from registers, never from out_stall
    assign occupancy = {1'b0, oq_count} + {{OQ_CNT_W{1'b0}}, res_valid};
    assign in_stall  = (occupancy >= (OQ_CNT_W + 1)'(OQ_DEPTH));
    assign in_accept = in_valid && !in_stall;

    // frame state, timers, checks and buffer
    mrfr_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_accept  (in_accept),
        .req_type   (req_type),
        .rx_byte    (rx_byte),
        .read_index (read_index),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .res_valid  (res_valid),
        .res        (res)
    );

    // results wait here while the output side stalls
    mrfr_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .count     (oq_count)
    );

    assign result_kind  = out_data.kind;
    assign frame_good   = out_data.good;
    assign frame_length = out_data.length;
    assign read_data    = out_data.data;

`ifndef SYNTHESIS
    a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        oq_count == OQ_CNT_W'(OQ_DEPTH) |-> in_stall)
        else $error("request accepted with full result queue");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && req_type == REQ_READ |=> res_valid && res.kind == KIND_READ)
        else $error("buffer read produced no result");

    a_no_result_on_byte: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && req_type == REQ_BYTE |=> !res_valid)
        else $error("received byte produced a result");
`endif

endmodule

// ----- rtl/mrfr_core.sv -----
// ----------------------------------------------------------------------------
// mrfr_core: frame state, silence timers and frame buffer
// Applies one accepted request per cycle to the frame state and writes any
// result into the result register; buffer reads come from a registered memory port.
// ----------------------------------------------------------------------------
module mrfr_core
    import mrfr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_accept,
    input  logic [1:0]   req_type,
    input  logic [7:0]   rx_byte,
    input  logic [7:0]   read_index,
    input  logic         cfg_write,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    output logic         res_valid,
    output mrfr_result_t res
);

    logic [7:0]       slave_addr_reg, slave_addr_next;
    logic [15:0]      t15_reg, t15_next;
    logic [15:0]      t35_reg, t35_next;
    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic             ok_reg, ok_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       first_byte_reg, first_byte_next;
    logic [15:0]      short_timer_reg, short_timer_next;
    logic             short_armed_reg, short_armed_next;
    logic [15:0]      long_timer_reg, long_timer_next;
    logic             long_armed_reg, long_armed_next;
    logic             res_valid_reg, res_valid_next;
    logic             res_kind_reg, res_kind_next;
    logic             res_good_reg, res_good_next;
    logic [8:0]       res_len_reg, res_len_next;

    logic [7:0]       mem [BUF_BYTES];
    logic [7:0]       rd_q_reg;
    logic             rd_oob_reg;
    logic             wr_en;
    logic             rd_en;
    logic             short_exp;
    logic             long_exp;
    logic             check_pass;
    logic             ok_tick;
    logic             rd_in_range;

    assign rd_in_range = ({1'b0, read_index} < CNT_W'(BUF_BYTES));

    // address, length and crc checks at the end of the short silence
    assign check_pass = (byte_count_reg >= CNT_W'(CHECK_MIN_BYTES)) &&
                        (byte_count_reg <= CNT_W'(BUF_BYTES)) &&
                        ((first_byte_reg == slave_addr_reg) ||
                         (first_byte_reg == BCAST_ADDR)) &&
                        (crc_reg == 16'h0000);

    always_comb
    begin
        slave_addr_next  = slave_addr_reg;
        t15_next         = t15_reg;
        t35_next         = t35_reg;
        byte_count_next  = byte_count_reg;
        ok_next          = ok_reg;
        crc_next         = crc_reg;
        first_byte_next  = first_byte_reg;
        short_timer_next = short_timer_reg;
        short_armed_next = short_armed_reg;
        long_timer_next  = long_timer_reg;
        long_armed_next  = long_armed_reg;
        res_valid_next   = 1'b0;
        res_kind_next    = res_kind_reg;
        res_good_next    = res_good_reg;
        res_len_next     = res_len_reg;
        wr_en            = 1'b0;
        rd_en            = 1'b0;
        short_exp        = 1'b0;
        long_exp         = 1'b0;
        ok_tick          = ok_reg;

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_SLAVE_ADDR: slave_addr_next = cfg_data[7:0];
                CFG_T15_TICKS:  t15_next = cfg_data;
                CFG_T35_TICKS:  t35_next = cfg_data;
                default:        ;
            endcase
        end

        if (in_accept)
        begin
            case (req_type)
                REQ_BYTE:
                begin
                    if (byte_count_reg < CNT_W'(BUF_BYTES))
                    begin
                        wr_en           = 1'b1;
                        crc_next        = crc16_update(crc_reg, rx_byte);
                        byte_count_next = byte_count_reg + CNT_W'(1);
                        if (byte_count_reg == '0)
                        begin
                            first_byte_next = rx_byte;
                        end
                    end
                    short_timer_next = t15_reg;
                    short_armed_next = 1'b1;
                    long_timer_next  = t35_reg;
                    long_armed_next  = 1'b1;
                end
                REQ_TICK:
                begin
                    if (short_armed_reg)
                    begin
                        if (short_timer_reg <= 16'd1)
                        begin
                            short_timer_next = '0;
                            short_armed_next = 1'b0;
                            short_exp        = 1'b1;
                        end
                        else
                        begin
                            short_timer_next = short_timer_reg - 16'd1;
                        end
                    end
                    if (short_exp)
                    begin
                        ok_tick = check_pass;
                    end
                    ok_next = ok_tick;
                    if (long_armed_reg)
                    begin
                        if (long_timer_reg <= 16'd1)
                        begin
                            long_timer_next = '0;
                            long_armed_next = 1'b0;
                            long_exp        = 1'b1;
                        end
                        else
                        begin
                            long_timer_next = long_timer_reg - 16'd1;
                        end
                    end
                    if (long_exp)
                    begin
                        res_valid_next  = 1'b1;
                        res_kind_next   = KIND_VERDICT;
                        res_good_next   = ok_tick &&
                                          (byte_count_reg > CNT_W'(MIN_FRAME_BYTES)) &&
                                          (byte_count_reg < CNT_W'(BUF_BYTES));
                        res_len_next    = 9'(byte_count_reg);
                        byte_count_next = '0;
                        ok_next         = 1'b0;
                        crc_next        = CRC_INIT;
                    end
                end
                REQ_READ:
                begin
                    rd_en          = 1'b1;
                    res_valid_next = 1'b1;
                    res_kind_next  = KIND_READ;
                    res_good_next  = 1'b0;
                    res_len_next   = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr_reg  <= SLAVE_ADDR_RST;
            t15_reg         <= T15_TICKS_RST;
            t35_reg         <= T35_TICKS_RST;
            byte_count_reg  <= '0;
            ok_reg          <= 1'b0;
            crc_reg         <= CRC_INIT;
            short_timer_reg <= '0;
            short_armed_reg <= 1'b0;
            long_timer_reg  <= '0;
            long_armed_reg  <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            slave_addr_reg  <= slave_addr_next;
            t15_reg         <= t15_next;
            t35_reg         <= t35_next;
            byte_count_reg  <= byte_count_next;
            ok_reg          <= ok_next;
            crc_reg         <= crc_next;
            short_timer_reg <= short_timer_next;
            short_armed_reg <= short_armed_next;
            long_timer_reg  <= long_timer_next;
            long_armed_reg  <= long_armed_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        first_byte_reg <= first_byte_next;
        res_kind_reg   <= res_kind_next;
        res_good_reg   <= res_good_next;
        res_len_reg    <= res_len_next;
    end

    // frame buffer, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[byte_count_reg[ADDR_W-1:0]] <= rx_byte;
        end
        if (rd_en)
        begin
            rd_q_reg   <= mem[read_index[ADDR_W-1:0]];
            rd_oob_reg <= !rd_in_range;
        end
    end

    assign res_valid   = res_valid_reg;
    assign res.kind    = res_kind_reg;
    assign res.good    = res_good_reg;
    assign res.length  = res_len_reg;
    assign res.data    = (res_kind_reg == KIND_READ && !rd_oob_reg) ? rd_q_reg : 8'h00;

`ifndef SYNTHESIS
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= CNT_W'(BUF_BYTES))
        else $error("byte count beyond buffer size");

    a_short_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !short_armed_reg |-> short_timer_reg == 16'd0)
        else $error("disarmed short timer not at zero");

    a_verdict_clears: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_kind_reg == KIND_VERDICT |->
            byte_count_reg == '0 && !ok_reg && crc_reg == CRC_INIT)
        else $error("frame state not cleared after verdict");

    a_read_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_kind_reg == KIND_READ |->
            !res_good_reg && res_len_reg == 9'd0)
        else $error("read result carries verdict fields");
`endif

endmodule

// ----- rtl/mrfr_out_queue.sv -----
// ----------------------------------------------------------------------------
// mrfr_out_queue: small result queue in front of the output channel
// Holds finished results while the downstream side stalls.
// ----------------------------------------------------------------------------
module mrfr_out_queue
    import mrfr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mrfr_result_t        push_data,
    input  logic                out_stall,
    output logic                out_valid,
    output mrfr_result_t        out_data,
    output logic [OQ_CNT_W-1:0] count
);

    mrfr_result_t        entry_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OQ_CNT_W-1:0] count_reg, count_next;
    logic                pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign out_data  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + OQ_PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + OQ_PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + OQ_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - OQ_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg < OQ_CNT_W'(OQ_DEPTH))
        else $error("push into full result queue");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= OQ_CNT_W'(OQ_DEPTH))
        else $error("result queue count out of range");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !push |=> count_reg == $past(count_reg) - OQ_CNT_W'(1))
        else $error("result queue count not reduced on pop");
`endif

endmodule

// ----- tb/modbus_rtu_frame_receiver_tb.sv -----
// ----------------------------------------------------------------------------
// modbus_rtu_frame_receiver_tb: self-checking bench for the frame receiver
// Sends received bytes, ticks and buffer reads, keeps its own copy of the
// timers, crc and frame buffer, and compares every verdict and read result
// field by field while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_receiver_tb;
    import mrfr_pkg::*;

    localparam int     HALF_PERIOD   = 10;
    localparam int     RESET_CYCLES  = 9;
    localparam int     SETTLE_CYCLES = 8;      // result register plus output queue, with margin
    localparam int     DRAIN_CYCLES  = 20000;
    localparam int     RANDOM_ITEMS  = 800;
    localparam int     PHASE_ITEMS   = 150;
    localparam int     LONG_WAIT     = 300;    // ticks that stay well inside the largest loads
    localparam longint RUN_LIMIT     = 60_000_000;

    // codes the block ignores
    localparam logic [1:0] REQ_NONE   = 2'd3;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef enum int {FLAW_NONE, FLAW_CRC, FLAW_BODY, FLAW_NO_CRC} frame_flaw_t;
    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    // dut ports, all known from time zero
    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type   = REQ_TICK;
    logic [7:0]  rx_byte    = 8'h00;
    logic [7:0]  read_index = 8'h00;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic        result_kind;
    logic        frame_good;
    logic [8:0]  frame_length;
    logic [7:0]  read_data;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index  = CFG_SLAVE_ADDR;
    logic [15:0] cfg_data   = 16'h0000;

    // receiver copy: registers
    logic [7:0]  own_addr  = SLAVE_ADDR_RST;
    logic [15:0] t15_load  = T15_TICKS_RST;
    logic [15:0] t35_load  = T35_TICKS_RST;

    // receiver copy: frame state and timers
    logic [7:0]  rx_mem [BUF_BYTES];
    logic [8:0]  rx_count  = '0;
    logic        rx_ok     = 1'b0;
    logic [15:0] rx_crc    = CRC_INIT;
    logic [15:0] t15_left  = '0;
    logic        t15_run   = 1'b0;
    logic [15:0] t35_left  = '0;
    logic        t35_run   = 1'b0;
    int          fill_mark = 0;        // entries below this were written at least once

    mrfr_result_t results_due[$];
    mrfr_result_t due;
    logic [7:0]   frame_bytes[$];

    // sender burst shaping
    bit gaps_on    = 1'b1;
    int burst_left = 8;

    // bookkeeping
    int error_count    = 0;
    int accepted_items = 0;
    int reg_writes     = 0;
    int good_verdicts  = 0;
    int bad_verdicts   = 0;
    int reads_seen     = 0;

    // receiver stall pattern
    stall_mode_t stall_mode = STALL_NONE;
    int          stall_hold = 0;
    int          stall_tick = 0;

    modbus_rtu_frame_receiver dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .rx_byte      (rx_byte),
        .read_index   (read_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .frame_good   (frame_good),
        .frame_length (frame_length),
        .read_data    (read_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // run limit, far beyond the slowest correct run
    initial
    begin
        #(RUN_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------------

    function automatic logic [7:0] rand8();
        logic [31:0] r;
        r = $urandom;
        return r[7:0];
    endfunction

    // modbus crc-16, bit-serial form: feedback is the low crc bit xor the data bit
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 0; k < 8; k++)
        begin
            fb = c[0] ^ b[k];
            c  = {1'b0, c[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    // only entries written at least once may be read back
    function automatic logic [7:0] pick_read_index();
        int v;
        v = $urandom_range(0, fill_mark - 1);
        return v[7:0];
    endfunction

    // advance the receiver copy by one accepted request and queue any result
    task automatic frame_rx_step(input logic [1:0] kind, input logic [7:0] b,
                                 input logic [7:0] idx);
        mrfr_result_t r;
        bit           t15_fired;
        r         = '0;
        t15_fired = 1'b0;
        case (kind)
            REQ_BYTE:
            begin
                // bytes past the buffer are dropped, the count saturates
                if (rx_count < BUF_BYTES)
                begin
                    rx_mem[rx_count[7:0]] = b;
                    rx_crc                = crc_step(rx_crc, b);
                    rx_count              = rx_count + 9'd1;
                    if (int'(rx_count) > fill_mark)
                        fill_mark = int'(rx_count);
                end
                // every byte restarts both silence timers
                t15_left = t15_load;
                t15_run  = 1'b1;
                t35_left = t35_load;
                t35_run  = 1'b1;
            end
            REQ_TICK:
            begin
                // 1.5 char timer first; a zero load expires on the first tick
                if (t15_run)
                begin
                    if (t15_left <= 16'd1)
                    begin
                        t15_left  = '0;
                        t15_run   = 1'b0;
                        t15_fired = 1'b1;
                    end
                    else
                        t15_left = t15_left - 16'd1;
                end
                if (t15_fired)
                    rx_ok = (rx_count >= CHECK_MIN_BYTES) && (rx_count <= BUF_BYTES) &&
                            (rx_mem[0] == own_addr || rx_mem[0] == BCAST_ADDR) &&
                            (rx_crc == 16'h0000);
                // 3.5 char timer ends the frame
                if (t35_run)
                begin
                    if (t35_left <= 16'd1)
                    begin
                        t35_left = '0;
                        t35_run  = 1'b0;
                        r.kind   = KIND_VERDICT;
                        r.good   = rx_ok && (rx_count > MIN_FRAME_BYTES) &&
                                   (rx_count < BUF_BYTES);
                        r.length = rx_count;
                        results_due.push_back(r);
                        rx_count = '0;
                        rx_ok    = 1'b0;
                        rx_crc   = CRC_INIT;
                    end
                    else
                        t35_left = t35_left - 16'd1;
                end
            end
            REQ_READ:
            begin
                r.kind = KIND_READ;
                r.data = rx_mem[idx];
                results_due.push_back(r);
            end
            default: ;
        endcase
    endtask

    // one request: hold it until accepted, then maybe end the burst
    task automatic send_request(input logic [1:0] kind, input logic [7:0] b,
                                input logic [7:0] idx);
        in_valid   <= 1'b1;
        req_type   <= kind;
        rx_byte    <= b;
        read_index <= idx;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        frame_rx_step(kind, b, idx);
        if (kind != REQ_NONE)
            accepted_items++;
        if (gaps_on)
        begin
            if (burst_left <= 1)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                burst_left = $urandom_range(1, 16);
            end
            else
                burst_left--;
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_request(REQ_BYTE, b, rand8());
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_request(REQ_TICK, rand8(), rand8());
    endtask

    task automatic read_back(input logic [7:0] idx);
        send_request(REQ_READ, rand8(), idx);
    endtask

    // any request type with random fields, reads kept to written entries
    task automatic send_noise(input int n);
        int k;
        repeat (n)
        begin
            k = $urandom_range(0, 3);
            if (k == REQ_READ && fill_mark > 0)
                read_back(pick_read_index());
            else if (k == REQ_READ)
                send_ticks(1);
            else
                send_request(k[1:0], rand8(), rand8());
        end
    endtask

    // address, body bytes, then the crc low byte first, with an optional flaw
    task automatic build_frame(input logic [7:0] addr, input int body_len,
                               input frame_flaw_t flaw);
        logic [15:0] c;
        int          pos;
        frame_bytes.delete();
        frame_bytes.push_back(addr);
        for (int k = 0; k < body_len; k++)
            frame_bytes.push_back(rand8());
        c = CRC_INIT;
        foreach (frame_bytes[k])
            c = crc_step(c, frame_bytes[k]);
        if (flaw != FLAW_NO_CRC)
        begin
            frame_bytes.push_back(c[7:0]);
            frame_bytes.push_back(c[15:8]);
        end
        if (flaw == FLAW_CRC)
        begin
            pos = frame_bytes.size() - 1 - $urandom_range(0, 1);
            frame_bytes[pos] = frame_bytes[pos] ^ (8'h01 << $urandom_range(0, 7));
        end
        if (flaw == FLAW_BODY)
        begin
            pos = $urandom_range(0, body_len);
            frame_bytes[pos] = frame_bytes[pos] ^ (8'h01 << $urandom_range(0, 7));
        end
    endtask

    // silence inside a frame: mostly shorter than the 1.5 char interval,
    // now and then anything, plus the odd read or ignored request
    task automatic inter_byte_pause();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12)
            send_ticks($urandom_range(0, (t15_load > 1) ? t15_load - 1 : 0));
        else if (r < 15 && fill_mark > 0)
            read_back(pick_read_index());
        else if (r == 15)
            send_ticks($urandom_range(0, t35_load + 1));
        else if (r == 16)
            send_request(REQ_NONE, rand8(), rand8());
    endtask

    task automatic send_frame(input bit with_pauses);
        foreach (frame_bytes[k])
        begin
            if (k > 0 && with_pauses)
                inter_byte_pause();
            send_byte(frame_bytes[k]);
        end
    endtask

    // enough silence for the 3.5 char timer to end the frame
    task automatic close_frame();
        send_ticks((t35_load == 0) ? 1 : t35_load);
    endtask

    // let every expected result come back, then let the pipeline settle
    task automatic wait_results_done();
        int n;
        n = 0;
        in_valid <= 1'b0;
        while (results_due.size() != 0 && n < DRAIN_CYCLES)
        begin
            @(posedge clk);
            n++;
        end
        if (results_due.size() != 0)
        begin
            $error("%0d results never arrived", results_due.size());
            error_count++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        case (idx)
            CFG_SLAVE_ADDR: own_addr = value[7:0];
            CFG_T15_TICKS:  t15_load = value;
            CFG_T35_TICKS:  t35_load = value;
            default: ;
        endcase
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // registers change only with the block idle
    task automatic set_config(input int addr, input int t15, input int t35);
        wait_results_done();
        write_register(CFG_SLAVE_ADDR, {8'h00, addr[7:0]});
        write_register(CFG_T15_TICKS, t15[15:0]);
        write_register(CFG_T35_TICKS, t35[15:0]);
    endtask

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (results_due.size() == 0)
            begin
                $error("result with none expected: kind %0d length %0d data %0h",
                       result_kind, frame_length, read_data);
                error_count++;
            end
            else
            begin
                due = results_due.pop_front();
                if (result_kind !== due.kind)
                begin
                    $error("result_kind: expected %0d, got %0d", due.kind, result_kind);
                    error_count++;
                end
                if (frame_good !== due.good)
                begin
                    $error("frame_good: expected %0d, got %0d", due.good, frame_good);
                    error_count++;
                end
                if (frame_length !== due.length)
                begin
                    $error("frame_length: expected %0d, got %0d", due.length, frame_length);
                    error_count++;
                end
                if (read_data !== due.data)
                begin
                    $error("read_data: expected %0h, got %0h", due.data, read_data);
                    error_count++;
                end
                if (due.kind == KIND_READ)
                    reads_seen++;
                else if (due.good)
                    good_verdicts++;
                else
                    bad_verdicts++;
            end
        end
    end

    // receiver stall: modes of random length, including stretches with no stall
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1;
        if (stall_hold == 0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            stall_hold <= $urandom_range(30, 300);
        end
        else
            stall_hold <= stall_hold - 1;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= (stall_tick % 7 < 3);
        endcase
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset registers: address 1, 16/36 ticks; a gap one short of the
    // 1.5 char interval keeps the frame open
    task automatic test_reset_defaults();
        build_frame(SLAVE_ADDR_RST, 3, FLAW_NONE);
        foreach (frame_bytes[k])
        begin
            if (k == 3)
                send_ticks(int'(T15_TICKS_RST) - 1);
            send_byte(frame_bytes[k]);
        end
        close_frame();
        read_back(8'd0);
        read_back(8'd5);
    endtask

    // own address, broadcast, foreign address, at both address extremes
    task automatic test_address_match();
        set_config(8'hFF, 2, 4);
        build_frame(8'hFF, 2, FLAW_NONE);
        send_frame(1'b0);
        close_frame();
        build_frame(BCAST_ADDR, 2, FLAW_NONE);
        send_frame(1'b0);
        close_frame();
        build_frame(8'h01, 2, FLAW_NONE);
        send_frame(1'b0);
        close_frame();
        set_config(8'h00, 2, 4);
        build_frame(BCAST_ADDR, 3, FLAW_NONE);
        send_frame(1'b0);
        close_frame();
        build_frame(8'hFF, 3, FLAW_NONE);
        send_frame(1'b0);
        close_frame();
    endtask

    // bad crc, corrupted body, missing crc, too short to check, exactly the
    // minimum that passes the check but not the length limit
    task automatic test_crc_and_short_frames();
        set_config(8'h11, 1, 3);
        build_frame(8'h11, 3, FLAW_CRC);
        send_frame(1'b0);
        close_frame();
        build_frame(8'h11, 3, FLAW_BODY);
        send_frame(1'b0);
        close_frame();
        build_frame(8'h11, 3, FLAW_NO_CRC);
        send_frame(1'b0);
        close_frame();
        build_frame(8'h11, 0, FLAW_NONE);
        send_frame(1'b0);
        close_frame();
        build_frame(8'h11, 1, FLAW_NONE);
        send_frame(1'b0);
        close_frame();
    endtask

    // longest good frame, a full buffer, and an overlong frame that saturates
    task automatic test_length_limits();
        set_config(8'h22, 1, 2);
        build_frame(8'h22, BUF_BYTES - 4, FLAW_NONE);
        send_frame(1'b0);
        close_frame();
        build_frame(8'h22, BUF_BYTES - 3, FLAW_NONE);
        send_frame(1'b0);
        close_frame();
        build_frame(8'h22, BUF_BYTES + 40, FLAW_NONE);
        send_frame(1'b0);
        close_frame();
        read_back(8'd255);
        read_back(8'd128);
        read_back(8'd127);
        read_back(8'd0);
    endtask

    // zero loads, both timers on one tick, long timer before short timer,
    // early check mid frame, and the largest loads
    task automatic test_timer_edges();
        set_config(8'h01, 0, 0);
        build_frame(8'h01, 2, FLAW_NONE);
        send_frame(1'b0);
        close_frame();
        set_config(8'h01, 5, 2);
        build_frame(8'h01, 2, FLAW_NONE);
        send_frame(1'b0);
        send_ticks(5);
        set_config(8'h01, 3, 6);
        build_frame(8'h01, 4, FLAW_NONE);
        foreach (frame_bytes[k])
        begin
            if (k == 2)
                send_ticks(3);
            send_byte(frame_bytes[k]);
        end
        close_frame();
        gaps_on = 1'b0;
        // largest long load: no verdict while it counts, then a late byte
        // under short loads joins the open frame and ends it
        set_config(8'h01, 2, 65535);
        build_frame(8'h01, 2, FLAW_NONE);
        send_frame(1'b0);
        send_ticks(LONG_WAIT);
        set_config(8'h01, 2, 3);
        send_byte(rand8());
        close_frame();
        // largest short load: the verdict comes first, the short timer runs on
        set_config(8'h01, 65535, 1);
        build_frame(8'h01, 2, FLAW_NONE);
        send_frame(1'b0);
        send_ticks(LONG_WAIT);
        gaps_on = 1'b1;
    endtask

    // the ignored request type mid frame and a write to the unused index
    task automatic test_unused_codes();
        set_config(8'h05, 2, 3);
        write_register(CFG_UNUSED, 16'hFFFF);
        build_frame(8'h05, 3, FLAW_NONE);
        foreach (frame_bytes[k])
        begin
            send_request(REQ_NONE, rand8(), rand8());
            send_byte(frame_bytes[k]);
        end
        send_request(REQ_NONE, 8'h00, 8'hFF);
        close_frame();
    endtask

    // mostly well-formed frames with random content and timing, plus reads,
    // noise and broken frames; each phase has its own register setting
    task automatic test_random_traffic();
        int          start;
        int          phase_end;
        int          phase;
        int          addr;
        int          t15;
        int          t35;
        int          r;
        int          body_len;
        logic [7:0]  dest;
        frame_flaw_t flaw;
        bit          paused;
        start = accepted_items;
        phase = 0;
        while (accepted_items - start < RANDOM_ITEMS)
        begin
            addr = (phase == 0) ? 255 : (phase == 1) ? 0 : $urandom_range(0, 255);
            t15  = (phase == 2) ? 0 : $urandom_range(1, 4);
            t35  = (phase == 3) ? 1 : $urandom_range(1, 9);
            set_config(addr, t15, t35);
            gaps_on   = (phase % 4 != 2);
            phase_end = accepted_items + PHASE_ITEMS;
            paused    = 1'b0;
            while (accepted_items < phase_end)
            begin
                // hold off until every expected result is back
                if (!paused && accepted_items > phase_end - PHASE_ITEMS / 2)
                begin
                    wait_results_done();
                    paused = 1'b1;
                end
                r = $urandom_range(0, 9);
                if (r < 7 || r == 9)
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: dest = own_addr;
                        5, 6:          dest = BCAST_ADDR;
                        default:       dest = rand8();
                    endcase
                    body_len = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 1) :
                               ($urandom_range(0, 24) == 0) ? $urandom_range(9, 40) :
                               $urandom_range(2, 8);
                    flaw = ($urandom_range(0, 9) < 7) ? FLAW_NONE :
                           frame_flaw_t'($urandom_range(1, 3));
                    build_frame(dest, body_len, flaw);
                    // broken frame: cut off partway
                    if (r == 9)
                        repeat ($urandom_range(1, frame_bytes.size() - 1))
                            void'(frame_bytes.pop_back());
                    send_frame(1'b1);
                    close_frame();
                    send_ticks($urandom_range(0, 2));
                end
                else if (r == 7 && fill_mark > 0)
                begin
                    repeat ($urandom_range(1, 4))
                        read_back(pick_read_index());
                end
                else
                    send_noise($urandom_range(1, 6));
            end
            phase++;
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_address_match();
        test_crc_and_short_frames();
        test_length_limits();
        test_timer_edges();
        test_unused_codes();
        test_random_traffic();

        wait_results_done();
        $display("run: %0d requests accepted, %0d register writes", accepted_items,
                 reg_writes);
        $display("checked: %0d frames accepted, %0d frames rejected, %0d buffer reads",
                 good_verdicts, bad_verdicts, reads_seen);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- modbus_rtu_frame_receiver.f -----
rtl/mrfr_pkg.sv
rtl/mrfr_core.sv
rtl/mrfr_out_queue.sv
rtl/modbus_rtu_frame_receiver.sv
tb/modbus_rtu_frame_receiver_tb.sv
